// File: sv/exl_pkg.sv
package exl_pkg;

   localparam int QPTR_W      = 2;
   localparam int QUEUE_DEPTH = 1 << QPTR_W;

   typedef struct packed {
      logic [7:0]  tok_char;
      logic [4:0]  tok_kind;
      logic        tok_first;
      logic        tok_last;
      logic [15:0] token_index;
      logic        run_last;
   } result_type;

   // results caused by one input transaction; r1 is used only when two is set
   typedef struct packed {
      logic       two;
      result_type r0;
      result_type r1;
   } group_type;

endpackage

// File: sv/expression_lexer.sv
// A result passes a queue entry and then the serializer's current-group register before it is
// presented. One character is taken per cycle while the queue is not full; a character that
// causes two results queues them as one group, and the four-group queue between classifier and
// serializer absorbs bursts; the serializer's one result per ready cycle sets the output rate.
// Reset (synchronous, active high) returns the lexer to idle, clears the token count,
// empties the queue and drops any result being presented.
module expression_lexer import exl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tlast,   // end_of_string
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] tok_char, [23:8] token_index
   output logic [6:0]  rsp_tuser,   // [4:0] tok_kind, [5] tok_first, [6] run_last
   output logic        rsp_tlast    // tok_last
);

   logic       push, q_full, q_pop, q_valid;
   group_type  push_data, q_data;
   result_type res;

   exl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_ch     (req_tdata),
      .in_eos    (req_tlast),
      .push      (push),
      .push_data (push_data),
      .q_full    (q_full)
   );

   exl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .out_valid (q_valid),
      .out_data  (q_data)
   );

   exl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (res)
   );

   assign rsp_tdata = {res.token_index, res.tok_char};
   assign rsp_tuser = {res.run_last, res.tok_first, res.tok_kind};
   assign rsp_tlast = res.tok_last;

endmodule

// File: sv/exl_front.sv
module exl_front import exl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_ch,
   input  logic       in_eos,
   output logic       push,
   output group_type  push_data,
   input  logic       q_full
);

   localparam logic [1:0] MODE_IDLE  = 2'd0;
   localparam logic [1:0] MODE_IDENT = 2'd1;
   localparam logic [1:0] MODE_NUM   = 2'd2;
   localparam logic [1:0] MODE_REL   = 2'd3;

   localparam logic [4:0] KIND_IDENT  = 5'd0;
   localparam logic [4:0] KIND_NUMBER = 5'd1;
   localparam logic [4:0] KIND_OTHER  = 5'd25;

   localparam logic [7:0] CH_DOT = 8'h2E;
   localparam logic [7:0] CH_EQ  = 8'h3D;
   localparam logic [7:0] CH_GT  = 8'h3E;
   localparam logic [7:0] CH_LT  = 8'h3C;

   function automatic logic [4:0] punct_kind(input logic [7:0] c);
      logic [4:0] k;
      case (c)
         8'h3B: k = 5'd2;   // ;
         8'h2C: k = 5'd3;   // ,
         8'h7B: k = 5'd4;   // {
         8'h7D: k = 5'd5;   // }
         8'h28: k = 5'd6;   // (
         8'h29: k = 5'd7;   // )
         8'h3E: k = 5'd8;   // >
         8'h3C: k = 5'd10;  // <
         8'h3D: k = 5'd12;  // =
         8'h5B: k = 5'd14;  // [
         8'h5D: k = 5'd15;  // ]
         8'h2B: k = 5'd16;  // +
         8'h2D: k = 5'd17;  // -
         8'h2A: k = 5'd18;  // *
         8'h2F: k = 5'd19;  // /
         8'h25: k = 5'd20;  // %
         8'h27: k = 5'd21;  // '
         8'h22: k = 5'd22;  // "
         8'h5C: k = 5'd23;  // backslash
         8'h3F: k = 5'd24;  // ?
         default: k = KIND_OTHER;
      endcase
      return k;
   endfunction

   function automatic result_type mk(input logic [7:0] c, input logic [4:0] k,
                                     input logic f, input logic l,
                                     input logic [15:0] idx);
      result_type r;
      r.tok_char    = c;
      r.tok_kind    = k;
      r.tok_first   = f;
      r.tok_last    = l;
      r.token_index = idx;
      r.run_last    = 1'b0;
      return r;
   endfunction

   function automatic group_type put(input group_type g, input logic [1:0] n,
                                     input result_type r);
      group_type o;
      o = g;
      if (n == 2'd0) begin
         o.r0 = r;
      end else begin
         o.r1 = r;
      end
      return o;
   endfunction

   logic [1:0]  mode_ff, mode_in;
   logic [7:0]  held_char_ff, held_char_in;
   logic [4:0]  held_kind_ff, held_kind_in;
   logic        held_first_ff, held_first_in;
   logic [15:0] count_ff, count_in;

   logic        accept;
   logic        is_letter, is_digit, is_punct, is_rel;
   logic        cont, start;
   logic [1:0]  n;
   logic [4:0]  rel_kind;
   group_type   g;

   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;

   assign is_letter = (in_ch inside {[8'h41:8'h5A], [8'h61:8'h7A]});
   assign is_digit  = (in_ch inside {[8'h30:8'h39]});
   assign is_punct  = (in_ch inside {[8'h21:8'h2F], [8'h3A:8'h40], [8'h5B:8'h60],
                                     [8'h7B:8'h7E]});
   assign is_rel    = (in_ch == CH_GT) || (in_ch == CH_LT) || (in_ch == CH_EQ);
   assign rel_kind  = held_kind_ff + 5'd1;

   always_comb begin
      mode_in       = mode_ff;
      held_char_in  = held_char_ff;
      held_kind_in  = held_kind_ff;
      held_first_in = held_first_ff;
      count_in      = count_ff;
      n             = 2'd0;
      g             = '0;
      cont          = 1'b0;
      start         = 1'b0;

      case (mode_ff)
         MODE_IDENT, MODE_NUM: begin
            cont = (mode_ff == MODE_IDENT) ? (is_letter || is_digit)
                                           : (is_digit || in_ch == CH_DOT);
            if (cont) begin
               g = put(g, n, mk(held_char_ff, held_kind_ff, held_first_ff, 1'b0,
                                count_in));
               n = n + 2'd1;
               held_char_in  = in_ch;
               held_first_in = 1'b0;
            end else begin
               g = put(g, n, mk(held_char_ff, held_kind_ff, held_first_ff, 1'b1,
                                count_in));
               n = n + 2'd1;
               count_in = count_in + 16'd1;
               start = 1'b1;
            end
         end
         MODE_REL: begin
            if (in_ch == CH_EQ) begin
               g = put(g, n, mk(held_char_ff, rel_kind, 1'b1, 1'b0, count_in));
               n = n + 2'd1;
               g = put(g, n, mk(in_ch, rel_kind, 1'b0, 1'b1, count_in));
               n = n + 2'd1;
               count_in = count_in + 16'd1;
               mode_in  = MODE_IDLE;
            end else begin
               g = put(g, n, mk(held_char_ff, held_kind_ff, 1'b1, 1'b1, count_in));
               n = n + 2'd1;
               count_in = count_in + 16'd1;
               start = 1'b1;
            end
         end
         default: start = 1'b1;
      endcase

      if (start) begin
         mode_in = MODE_IDLE;
         if (is_letter) begin
            held_char_in  = in_ch;
            held_kind_in  = KIND_IDENT;
            held_first_in = 1'b1;
            mode_in       = MODE_IDENT;
         end else if (is_digit) begin
            held_char_in  = in_ch;
            held_kind_in  = KIND_NUMBER;
            held_first_in = 1'b1;
            mode_in       = MODE_NUM;
         end else if (is_rel) begin
            held_char_in  = in_ch;
            held_kind_in  = punct_kind(in_ch);
            held_first_in = 1'b1;
            mode_in       = MODE_REL;
         end else if (is_punct) begin
            g = put(g, n, mk(in_ch, punct_kind(in_ch), 1'b1, 1'b1, count_in));
            n = n + 2'd1;
            count_in = count_in + 16'd1;
         end
      end

      // end of string flushes whatever is held
      if (in_eos && mode_in != MODE_IDLE) begin
         g = put(g, n, mk(held_char_in, held_kind_in, held_first_in, 1'b1, count_in));
         n = n + 2'd1;
         count_in = count_in + 16'd1;
         mode_in  = MODE_IDLE;
      end

      if (n == 2'd1) begin
         g.r0.run_last = 1'b1;
      end else if (n == 2'd2) begin
         g.r1.run_last = 1'b1;
      end
      g.two = (n == 2'd2);
   end

   assign push      = accept && (n != 2'd0);
   assign push_data = g;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         held_char_ff  <= '0;
         held_kind_ff  <= '0;
         held_first_ff <= 1'b0;
         count_ff      <= '0;
      end else if (accept) begin
         mode_ff       <= mode_in;
         held_char_ff  <= held_char_in;
         held_kind_ff  <= held_kind_in;
         held_first_ff <= held_first_in;
         count_ff      <= count_in;
      end
   end

endmodule

// File: sv/exl_queue.sv
module exl_queue import exl_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  group_type push_data,
   output logic      full,
   input  logic      pop,
   output logic      out_valid,
   output group_type out_data
);

   group_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_pop;

   assign full      = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign do_pop    = pop && out_valid;

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

// File: sv/exl_back.sv
module exl_back import exl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  group_type  q_data,
   output logic       q_pop,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   group_type cur_ff, cur_in;
   logic      cur_valid_ff, cur_valid_in;
   logic      beat_ff, beat_in;
   logic      fire, final_beat, load;

   assign out_valid  = cur_valid_ff;
   assign out_data   = beat_ff ? cur_ff.r1 : cur_ff.r0;
   assign fire       = cur_valid_ff && out_ready;
   assign final_beat = !cur_ff.two || beat_ff;
   assign load       = !cur_valid_ff || (fire && final_beat);
   assign q_pop      = load && q_valid;

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      beat_in      = beat_ff;
      if (load) begin
         cur_in       = q_data;
         cur_valid_in = q_valid;
         beat_in      = 1'b0;
      end else if (fire) begin
         beat_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         beat_ff      <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         beat_ff      <= beat_in;
      end
   end

   // second beat only exists inside a two-result group
   assert property (@(posedge clock) disable iff (reset)
      beat_ff |-> (cur_valid_ff && cur_ff.two))
      else $error("second beat without a two-result group");

   assert property (@(posedge clock) disable iff (reset)
      (fire && !final_beat) |=> (cur_valid_ff && beat_ff))
      else $error("first beat of pair taken but second not presented");

   // the second result of a pair always closes a token and the transaction
   assert property (@(posedge clock) disable iff (reset)
      (cur_valid_ff && beat_ff) |-> (out_data.tok_last && out_data.run_last))
      else $error("second result of pair not marked last");

endmodule

// File: sim/expression_lexer_checker.sv
module expression_lexer_checker import exl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tlast,   // end_of_string
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // [7:0] tok_char, [23:8] token_index
   input  logic [6:0]  rsp_tuser,   // [4:0] tok_kind, [5] tok_first, [6] run_last
   input  logic        rsp_tlast,   // tok_last
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   typedef enum logic [1:0] {LEX_IDLE, LEX_IDENT, LEX_NUMBER, LEX_REL} lex_mode_type;

   typedef enum logic [4:0] {
      KIND_IDENT, KIND_NUMBER, KIND_SEMI, KIND_COMMA, KIND_LBRACE, KIND_RBRACE,
      KIND_LPAREN, KIND_RPAREN, KIND_GT, KIND_GE, KIND_LT, KIND_LE, KIND_ASSIGN,
      KIND_EQ, KIND_LBRACKET, KIND_RBRACKET, KIND_PLUS, KIND_MINUS, KIND_STAR,
      KIND_SLASH, KIND_PERCENT, KIND_SQUOTE, KIND_DQUOTE, KIND_BACKSLASH,
      KIND_QUESTION, KIND_OTHER
   } token_kind_type;

   lex_mode_type   mode;
   logic [7:0]     held_char;
   token_kind_type held_kind;
   logic           held_first;
   logic [15:0]    tok_count;
   int             mismatches;

   result_type  step_tokens[$];
   result_type  expected_tokens[$];

   function automatic bit is_letter(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_punct(logic [7:0] c);
      return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
             (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
   endfunction

   function automatic token_kind_type kind_of(logic [7:0] c);
      case (c)
         ";":     return KIND_SEMI;
         ",":     return KIND_COMMA;
         "{":     return KIND_LBRACE;
         "}":     return KIND_RBRACE;
         "(":     return KIND_LPAREN;
         ")":     return KIND_RPAREN;
         ">":     return KIND_GT;
         "<":     return KIND_LT;
         "=":     return KIND_ASSIGN;
         "[":     return KIND_LBRACKET;
         "]":     return KIND_RBRACKET;
         "+":     return KIND_PLUS;
         "-":     return KIND_MINUS;
         "*":     return KIND_STAR;
         "/":     return KIND_SLASH;
         "%":     return KIND_PERCENT;
         "'":     return KIND_SQUOTE;
         "\"":    return KIND_DQUOTE;
         "\\":    return KIND_BACKSLASH;
         "?":     return KIND_QUESTION;
         default: return KIND_OTHER;
      endcase
   endfunction

   task emit_token(input logic [7:0] c, input token_kind_type kind, input logic first,
                   input logic last);
      result_type r;
      r.tok_char    = c;
      r.tok_kind    = kind;
      r.tok_first   = first;
      r.tok_last    = last;
      r.token_index = tok_count;
      r.run_last    = 1'b0;
      step_tokens.push_back(r);
      if (last)
         tok_count = tok_count + 16'd1;
   endtask

   task hold_char(input logic [7:0] c, input token_kind_type kind,
                  input lex_mode_type next);
      held_char  = c;
      held_kind  = kind;
      held_first = 1'b1;
      mode       = next;
   endtask

   task start_token(input logic [7:0] c);
      mode = LEX_IDLE;
      if (is_letter(c))
         hold_char(c, KIND_IDENT, LEX_IDENT);
      else if (is_digit(c))
         hold_char(c, KIND_NUMBER, LEX_NUMBER);
      else if (c == ">" || c == "<" || c == "=")
         hold_char(c, kind_of(c), LEX_REL);
      else if (is_punct(c))
         emit_token(c, kind_of(c), 1'b1, 1'b1);
   endtask

   // one character in, up to two token characters queued as expected
   task lex_char(input logic [7:0] c, input logic eos);
      bit             cont;
      token_kind_type pair_kind;
      step_tokens.delete();
      case (mode)
         LEX_IDENT, LEX_NUMBER: begin
            cont = (mode == LEX_IDENT) ? (is_letter(c) || is_digit(c))
                                       : (is_digit(c) || c == ".");
            if (cont) begin
               emit_token(held_char, held_kind, held_first, 1'b0);
               held_char  = c;
               held_first = 1'b0;
            end else begin
               emit_token(held_char, held_kind, held_first, 1'b1);
               start_token(c);
            end
         end
         LEX_REL: begin
            if (c == "=") begin
               // >=, <= and == are the kind right after their single form
               pair_kind = token_kind_type'(held_kind + 5'd1);
               emit_token(held_char, pair_kind, 1'b1, 1'b0);
               emit_token(c, pair_kind, 1'b0, 1'b1);
               mode = LEX_IDLE;
            end else begin
               emit_token(held_char, held_kind, 1'b1, 1'b1);
               start_token(c);
            end
         end
         default: start_token(c);
      endcase
      if (eos && mode != LEX_IDLE) begin
         emit_token(held_char, held_kind, held_first, 1'b1);
         mode = LEX_IDLE;
      end
      if (step_tokens.size() > 0)
         step_tokens[step_tokens.size() - 1].run_last = 1'b1;
      foreach (step_tokens[i])
         expected_tokens.push_back(step_tokens[i]);
   endtask

   task check_token();
      result_type got;
      result_type want;
      got.tok_char    = rsp_tdata[7:0];
      got.token_index = rsp_tdata[23:8];
      got.tok_kind    = rsp_tuser[4:0];
      got.tok_first   = rsp_tuser[5];
      got.run_last    = rsp_tuser[6];
      got.tok_last    = rsp_tlast;
      if (expected_tokens.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("%0t: unexpected token transaction char %h kind %0d index %0d",
                     $realtime, got.tok_char, got.tok_kind, got.token_index);
      end else begin
         want = expected_tokens.pop_front();
         if (got.tok_char !== want.tok_char || got.tok_kind !== want.tok_kind ||
             got.tok_first !== want.tok_first || got.tok_last !== want.tok_last ||
             got.token_index !== want.token_index || got.run_last !== want.run_last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("%0t: token mismatch, expected char %h kind %0d first %b last %b",
                        $realtime, want.tok_char, want.tok_kind, want.tok_first,
                        want.tok_last);
               $display("   index %0d run_last %b; got char %h kind %0d first %b last %b",
                        want.token_index, want.run_last, got.tok_char, got.tok_kind,
                        got.tok_first, got.tok_last);
               $display("   index %0d run_last %b", got.token_index, got.run_last);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mode       = LEX_IDLE;
         held_char  = 8'h00;
         held_kind  = KIND_IDENT;
         held_first = 1'b0;
         tok_count  = 16'd0;
         expected_tokens.delete();
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_token();
         if (req_tvalid && req_tready)
            lex_char(req_tdata, req_tlast);
      end
      pending    <= expected_tokens.size();
      fail_count <= mismatches;
   end

endmodule

// File: sim/expression_lexer_tb.sv
module expression_lexer_tb;
   import exl_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_COUNT   = 1100;
   localparam int BURST_ITEMS  = 200;     // single-char tokens sent back to back
   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 1000000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic [6:0]  rsp_tuser;
   logic        rsp_tlast;

   int          fail_count;
   int          pending;
   int          cycle_count;
   int          items_sent;
   bit          squeeze;
   bit          drain_fast;
   bit          no_gaps;
   logic [7:0]  text[$];

   expression_lexer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   expression_lexer_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 93)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] random_letter();
      logic [7:0] base;
      base = $urandom_range(0, 1) ? "A" : "a";
      return base + 8'($urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] random_digit();
      return "0" + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] random_punct();
      int r;
      r = $urandom_range(0, 31);
      if (r < 15)
         return 8'h21 + 8'(r);
      else if (r < 22)
         return 8'h3A + 8'(r - 15);
      else if (r < 28)
         return 8'h5B + 8'(r - 22);
      else
         return 8'h7B + 8'(r - 28);
   endfunction

   task send_char(input logic [7:0] c, input logic eos);
      int gap;
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= eos;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // appends one lexeme, mostly well formed, sometimes whitespace or a raw byte
   task add_token();
      int r;
      int n;
      r = $urandom_range(0, 99);
      if (r < 30) begin
         text.push_back(random_letter());
         n = $urandom_range(0, 5);
         repeat (n) text.push_back($urandom_range(0, 2) ? random_letter() : random_digit());
      end else if (r < 50) begin
         text.push_back(random_digit());
         n = $urandom_range(0, 4);
         repeat (n) text.push_back($urandom_range(0, 3) ? random_digit() : ".");
      end else if (r < 65) begin
         text.push_back(random_punct());
      end else if (r < 75) begin
         case ($urandom_range(0, 2))
            0:       text.push_back(">");
            1:       text.push_back("<");
            default: text.push_back("=");
         endcase
         if ($urandom_range(0, 1))
            text.push_back("=");
      end else if (r < 87) begin
         case ($urandom_range(0, 2))
            0:       text.push_back(8'h20);
            1:       text.push_back(8'h09);
            default: text.push_back(8'h0A);
         endcase
      end else begin
         text.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   task send_string();
      int n;
      text.delete();
      n = $urandom_range(1, 8);
      repeat (n) add_token();
      foreach (text[i])
         send_char(text[i], i == text.size() - 1);
   endtask

   initial begin
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (squeeze) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            squeeze = 1'b0;
         end else if (drain_fast) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(0, 99) < 85 ? $urandom_range(1, 8)
                                               : $urandom_range(30, 80)) @(posedge clock);
            if (!squeeze && !drain_fast) begin
               automatic int stall = pick_gap();
               if (stall > 0) begin
                  rsp_tready <= 1'b0;
                  repeat (stall) @(posedge clock);
               end
            end
         end
      end
   end

   initial begin
      string      directed;
      logic [7:0] c;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'h00;
      req_tlast  <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // identifier, number with dots, relational pairs, lone dot, dropped bytes
      directed = "Az0 9..q>=<x==.";
      for (int i = 0; i < directed.len(); i++)
         send_char(directed[i], 1'b0);
      send_char(8'hFF, 1'b0);
      send_char(8'h00, 1'b0);
      send_char(8'h80, 1'b0);
      send_char("=", 1'b1);
      send_char("a", 1'b1);
      send_char("1", 1'b1);
      send_char(">", 1'b0);
      send_char(";", 1'b1);

      // back-to-back run of single-character tokens
      drain_fast = 1'b1;
      no_gaps    = 1'b1;
      for (int i = 0; i < BURST_ITEMS; i++) begin
         do
            c = random_punct();
         while (c == ">" || c == "<" || c == "=");
         send_char(c, i == BURST_ITEMS - 1);
      end
      drain_fast = 1'b0;
      no_gaps    = 1'b0;

      // receiver holds off while the sender keeps pushing
      squeeze    = 1'b1;
      no_gaps    = 1'b1;
      while (squeeze) send_string();
      no_gaps = 1'b0;

      while (items_sent < ITEM_COUNT) begin
         if ($urandom_range(0, 15) == 0)
            no_gaps = ~no_gaps;
         send_string();
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// File: sim.f
sv/exl_pkg.sv
sv/exl_front.sv
sv/exl_queue.sv
sv/exl_back.sv
sv/expression_lexer.sv
sim/expression_lexer_checker.sv
sim/expression_lexer_tb.sv
